/* sv/ssea_pkg.sv */
// Package: shared types and constants of the segment SSE accumulator.
`default_nettype none
package ssea_pkg;

   // Function codes of an input transaction
   localparam logic [1:0] FUNC_ACC   = 2'd0;
   localparam logic [1:0] FUNC_SAVE  = 2'd1;
   localparam logic [1:0] FUNC_CLEAR = 2'd2;
   localparam logic [1:0] FUNC_NOP   = 2'd3;   // unused code, only answers

   localparam logic [15:0] COUNT_MAX = 16'hFFFF;
   localparam logic [61:0] TOTAL_MAX = {62{1'b1}};
   localparam logic [63:0] ERR_MAX   = {64{1'b1}};

   // One lane entry of the statistics memory
   typedef struct packed {
      logic [15:0] count;
      logic [47:0] sum;       // signed Q32.16
      logic [63:0] sumsq;     // Q32.32
      logic [63:0] cur_err;   // error of the open segment
      logic [63:0] lane_err;  // saved error of closed segments
   } lane_entry_type;

   // Divider status
   typedef struct packed {
      logic done;
      logic ovf;
   } div_stat_type;

   typedef enum logic [3:0] {
      ST_INIT,
      ST_IDLE,
      ST_LOAD,
      ST_MUL_LO,
      ST_MUL_MID,
      ST_MUL_HI,
      ST_DIV_START,
      ST_DIV,
      ST_ERR,
      ST_SAVE,
      ST_CLEAR,
      ST_DONE
   } state_type;

endpackage
`default_nettype wire

/* sv/ssea_if.sv */
// Interfaces: request and response channels of the segment SSE accumulator.
`default_nettype none
interface ssea_req_if;
   logic        valid;
   logic        ready;
   logic [1:0]  func;
   logic [3:0]  lane;
   logic signed [31:0] value;
   logic        is_missing;
   logic        row_end;
   modport source (output valid, func, lane, value, is_missing, row_end, input ready);
   modport sink   (input valid, func, lane, value, is_missing, row_end, output ready);
endinterface

interface ssea_rsp_if;
   logic        valid;
   logic        ready;
   logic [61:0] total_cost;
   logic [15:0] rows_seen;
   modport source (output valid, total_cost, rows_seen, input ready);
   modport sink   (input valid, total_cost, rows_seen, output ready);
endinterface
`default_nettype wire

/* sv/ssea_lane_mem.sv */
// Lane statistics memory: one write port, one registered read port.
`default_nettype none
module ssea_lane_mem #(
   parameter int DEPTH = 16,
   parameter int AW    = 4
) (
   input  wire logic                    clock,
   input  wire logic                    wr_en,
   input  wire logic [AW-1:0]           wr_addr,
   input  wire ssea_pkg::lane_entry_type wr_data,
   input  wire logic [AW-1:0]           rd_addr,
   output ssea_pkg::lane_entry_type     rd_data
);

   ssea_pkg::lane_entry_type mem [DEPTH];
   ssea_pkg::lane_entry_type rd_data_ff;

   // write
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
   end

   // registered read
   always_ff @(posedge clock) begin
      rd_data_ff <= mem[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule
`default_nettype wire

/* sv/ssea_div.sv */
// Iterative divider: 96-bit dividend by 16-bit count, 64-bit quotient, two bits a cycle.
`default_nettype none
module ssea_div (
   input  wire logic                  clock,
   input  wire logic                  reset,
   input  wire logic                  start,
   input  wire logic [31:0]           num_hi,
   input  wire logic [63:0]           num_lo,
   input  wire logic [15:0]           den,
   output logic [63:0]                quotient,
   output ssea_pkg::div_stat_type     stat
);

   logic        busy_ff, busy_in;
   logic        done_ff, done_in;
   logic        ovf_ff;
   logic [4:0]  cnt_ff;
   logic [15:0] rem_ff;
   logic [63:0] quo_ff;

   logic [16:0] t1, t2, r1, r2;
   logic        b1, b2;

   // two restoring steps a cycle
   always_comb begin
      t1 = {rem_ff, quo_ff[63]};
      b1 = (t1 >= {1'b0, den});
      r1 = b1 ? (t1 - {1'b0, den}) : t1;
      t2 = {r1[15:0], quo_ff[62]};
      b2 = (t2 >= {1'b0, den});
      r2 = b2 ? (t2 - {1'b0, den}) : t2;
   end

   always_comb begin
      busy_in = busy_ff;
      done_in = 1'b0;
      if (start) begin
         busy_in = 1'b1;
      end else if (busy_ff && (cnt_ff == 5'd31)) begin
         busy_in = 1'b0;
         done_in = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
      end
   end

   // datapath
   always_ff @(posedge clock) begin
      if (start) begin
         // quotient overflows 64 bits when the upper word reaches the count
         ovf_ff <= ({16'd0, num_hi} >= {32'd0, den});
         rem_ff <= num_hi[15:0];
         quo_ff <= num_lo;
         cnt_ff <= 5'd0;
      end else if (busy_ff) begin
         rem_ff <= r2[15:0];
         quo_ff <= {quo_ff[61:0], b1, b2};
         cnt_ff <= cnt_ff + 5'd1;
      end
   end

   assign quotient  = quo_ff;
   assign stat.done = done_ff;
   assign stat.ovf  = ovf_ff;

endmodule
`default_nettype wire

/* sv/segment_sse_accumulator_core.sv */
// Segment sum-of-squared-errors accumulator. Each request transaction gives one
// response transaction: path loss plus saved and current segment error, Q32.32,
// saturating at 2^62-1. Items are handled one at a time. An accumulate of a present
// value in a valid lane passes the memory read, three partial-product multiplies,
// the radix-4 divider and the write-back; a missing value, an out-of-range lane or
// an unused code goes straight to the response. Save and clear sweep the lane
// memory one entry a cycle. After reset a clearing pass over every lane entry runs
// before the first request is taken; register writes are taken in any state, but a
// clear taken in the same cycle wins over them. The response sits in an output
// register, so a new request may enter while the previous response waits.
`default_nettype none
module segment_sse_accumulator_core #(
   parameter int NSAMP = 16
) (
   input  wire logic        clock,
   input  wire logic        reset,
   ssea_req_if.sink         req_ch,
   ssea_rsp_if.source       rsp_ch,
   input  wire logic        csr_we,
   input  wire logic [61:0] csr_wdata
);

   localparam int AW = (NSAMP > 1) ? $clog2(NSAMP) : 1;
   localparam int W  = 64 + AW + 1;   // wide error sums, never overflow

   ssea_pkg::state_type state_ff, state_in;

   // memory ports
   logic                     wr_en;
   logic [AW-1:0]            wr_addr, rd_addr;
   ssea_pkg::lane_entry_type wr_data, rd_data;

   // divider
   logic                     div_start;
   logic [95:0]              num;
   logic [63:0]              div_q;
   ssea_pkg::div_stat_type   div_stat;

   // working registers
   logic [61:0]              pl_ff;
   logic [15:0]              rows_ff;
   logic [W-1:0]             cur_acc_ff, saved_acc_ff;
   logic [AW-1:0]            idx_ff, lane_ff;
   logic                     last_idx;
   ssea_pkg::lane_entry_type ent_ff;
   logic [31:0]              value_ff;
   logic [63:0]              sq_ff;
   logic [63:0]              prod_lo_ff;
   logic [47:0]              prod_mid_ff;
   logic [31:0]              prod_hi_ff;
   logic [47:0]              mag_sum;

   // response register
   logic                     rsp_valid_ff;
   logic [61:0]              rsp_total_ff;
   logic [15:0]              rsp_rows_ff;

   logic                     accept, lane_ok, rsp_free;
   logic [31:0]              mag_val;
   logic [48:0]              sum_ext;
   logic [47:0]              sum_new;
   logic [64:0]              sumsq_ext;
   logic [64:0]              le_ext;
   logic [63:0]              q_sat, err_new, le_new;
   logic [W+1:0]             total_wide;

   assign accept   = req_ch.valid && req_ch.ready;
   assign lane_ok  = ({28'd0, req_ch.lane} < 32'(NSAMP));
   assign last_idx = (idx_ff == AW'(NSAMP - 1));
   assign rsp_free = !rsp_valid_ff || rsp_ch.ready;

   ssea_lane_mem #(.DEPTH(NSAMP), .AW(AW)) u_mem (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (wr_addr),
      .wr_data (wr_data),
      .rd_addr (rd_addr),
      .rd_data (rd_data)
   );

   ssea_div u_div (
      .clock    (clock),
      .reset    (reset),
      .start    (div_start),
      .num_hi   (num[95:64]),
      .num_lo   (num[63:0]),
      .den      (ent_ff.count),
      .quotient (div_q),
      .stat     (div_stat)
   );

   // value statistics update
   always_comb begin
      mag_val = value_ff[31] ? (32'd0 - value_ff) : value_ff;
      sum_ext = {rd_data.sum[47], rd_data.sum} + {{17{value_ff[31]}}, value_ff};
      if (sum_ext[48] != sum_ext[47]) begin
         sum_new = sum_ext[48] ? {1'b1, 47'd0} : {1'b0, {47{1'b1}}};
      end else begin
         sum_new = sum_ext[47:0];
      end
      sumsq_ext = {1'b0, ent_ff.sumsq} + {1'b0, sq_ff};
      mag_sum   = ent_ff.sum[47] ? (48'd0 - ent_ff.sum) : ent_ff.sum;
      num = {prod_hi_ff, 64'd0} + {15'd0, prod_mid_ff, 33'd0} + {32'd0, prod_lo_ff};
      q_sat   = div_stat.ovf ? ssea_pkg::ERR_MAX : div_q;
      err_new = (ent_ff.sumsq > q_sat) ? (ent_ff.sumsq - q_sat) : 64'd0;
      le_ext  = {1'b0, rd_data.lane_err} + {1'b0, rd_data.cur_err};
      le_new  = le_ext[64] ? ssea_pkg::ERR_MAX : le_ext[63:0];
      total_wide = (W+2)'(pl_ff) + (W+2)'(saved_acc_ff) + (W+2)'(cur_acc_ff);
   end

   // next state and memory control
   always_comb begin
      state_in  = state_ff;
      wr_en     = 1'b0;
      wr_addr   = idx_ff;
      wr_data   = '0;
      rd_addr   = idx_ff + AW'(1);
      div_start = 1'b0;
      req_ch.ready = 1'b0;
      case (state_ff)
         ssea_pkg::ST_INIT, ssea_pkg::ST_CLEAR: begin
            wr_en = 1'b1;
            if (last_idx) begin
               state_in = (state_ff == ssea_pkg::ST_INIT) ? ssea_pkg::ST_IDLE
                                                         : ssea_pkg::ST_DONE;
            end
         end
         ssea_pkg::ST_IDLE: begin
            req_ch.ready = 1'b1;
            rd_addr = (req_ch.func == ssea_pkg::FUNC_SAVE) ? '0 : AW'(req_ch.lane);
            if (req_ch.valid) begin
               case (req_ch.func)
                  ssea_pkg::FUNC_ACC: begin
                     state_in = (!req_ch.is_missing && lane_ok) ? ssea_pkg::ST_LOAD
                                                                : ssea_pkg::ST_DONE;
                  end
                  ssea_pkg::FUNC_SAVE:  state_in = ssea_pkg::ST_SAVE;
                  ssea_pkg::FUNC_CLEAR: state_in = ssea_pkg::ST_CLEAR;
                  default:              state_in = ssea_pkg::ST_DONE;
               endcase
            end
         end
         ssea_pkg::ST_LOAD:      state_in = ssea_pkg::ST_MUL_LO;
         ssea_pkg::ST_MUL_LO:    state_in = ssea_pkg::ST_MUL_MID;
         ssea_pkg::ST_MUL_MID:   state_in = ssea_pkg::ST_MUL_HI;
         ssea_pkg::ST_MUL_HI:    state_in = ssea_pkg::ST_DIV_START;
         ssea_pkg::ST_DIV_START: begin
            div_start = 1'b1;
            state_in  = ssea_pkg::ST_DIV;
         end
         ssea_pkg::ST_DIV: begin
            if (div_stat.done) begin
               state_in = ssea_pkg::ST_ERR;
            end
         end
         ssea_pkg::ST_ERR: begin
            wr_en   = 1'b1;
            wr_addr = lane_ff;
            wr_data = ent_ff;
            wr_data.cur_err = err_new;
            state_in = ssea_pkg::ST_DONE;
         end
         ssea_pkg::ST_SAVE: begin
            // fold open error into saved error, clear the statistics
            wr_en = 1'b1;
            wr_data.lane_err = le_new;
            if (last_idx) begin
               state_in = ssea_pkg::ST_DONE;
            end
         end
         ssea_pkg::ST_DONE: begin
            if (rsp_free) begin
               state_in = ssea_pkg::ST_IDLE;
            end
         end
         default: state_in = ssea_pkg::ST_INIT;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ssea_pkg::ST_INIT;
      end else begin
         state_ff <= state_in;
      end
   end

   // control registers: sweep index, totals, row count, path loss
   always_ff @(posedge clock) begin
      if (reset) begin
         idx_ff       <= '0;
         pl_ff        <= '0;
         rows_ff      <= '0;
         cur_acc_ff   <= '0;
         saved_acc_ff <= '0;
      end else begin
         // a clear taken in the same cycle wins over a register write
         if (csr_we && !(accept && (req_ch.func == ssea_pkg::FUNC_CLEAR))) begin
            pl_ff <= csr_wdata;
         end
         case (state_ff)
            ssea_pkg::ST_INIT, ssea_pkg::ST_CLEAR, ssea_pkg::ST_SAVE: begin
               idx_ff <= idx_ff + AW'(1);
               if (state_ff == ssea_pkg::ST_SAVE) begin
                  saved_acc_ff <= saved_acc_ff + W'(le_new);
               end
            end
            ssea_pkg::ST_IDLE: begin
               idx_ff <= '0;
               if (accept) begin
                  case (req_ch.func)
                     ssea_pkg::FUNC_ACC: begin
                        if (req_ch.row_end && (rows_ff != ssea_pkg::COUNT_MAX)) begin
                           rows_ff <= rows_ff + 16'd1;
                        end
                     end
                     ssea_pkg::FUNC_SAVE: begin
                        saved_acc_ff <= '0;
                        cur_acc_ff   <= '0;
                     end
                     ssea_pkg::FUNC_CLEAR: begin
                        pl_ff        <= '0;
                        rows_ff      <= '0;
                        saved_acc_ff <= '0;
                        cur_acc_ff   <= '0;
                     end
                     default: ;
                  endcase
               end
            end
            ssea_pkg::ST_ERR: begin
               cur_acc_ff <= cur_acc_ff - W'(ent_ff.cur_err) + W'(err_new);
            end
            default: ;
         endcase
      end
   end

   // accumulate datapath
   always_ff @(posedge clock) begin
      case (state_ff)
         ssea_pkg::ST_IDLE: begin
            value_ff <= req_ch.value;
            lane_ff  <= AW'(req_ch.lane);
         end
         ssea_pkg::ST_LOAD: begin
            ent_ff <= '{count:    (rd_data.count == ssea_pkg::COUNT_MAX)
                                  ? rd_data.count : rd_data.count + 16'd1,
                        sum:      sum_new,
                        sumsq:    rd_data.sumsq,
                        cur_err:  rd_data.cur_err,
                        lane_err: rd_data.lane_err};
            sq_ff  <= 64'(mag_val) * 64'(mag_val);
         end
         ssea_pkg::ST_MUL_LO: begin
            ent_ff.sumsq <= sumsq_ext[64] ? ssea_pkg::ERR_MAX : sumsq_ext[63:0];
            prod_lo_ff   <= 64'(mag_sum[31:0]) * 64'(mag_sum[31:0]);
         end
         ssea_pkg::ST_MUL_MID: begin
            prod_mid_ff <= 48'(mag_sum[47:32]) * 48'(mag_sum[31:0]);
         end
         ssea_pkg::ST_MUL_HI: begin
            prod_hi_ff <= 32'(mag_sum[47:32]) * 32'(mag_sum[47:32]);
         end
         default: ;
      endcase
   end

   // response register
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (state_ff == ssea_pkg::ST_DONE && rsp_free) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_ch.ready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (state_ff == ssea_pkg::ST_DONE && rsp_free) begin
         rsp_total_ff <= (total_wide > (W+2)'(ssea_pkg::TOTAL_MAX)) ? ssea_pkg::TOTAL_MAX
                                                                     : total_wide[61:0];
         rsp_rows_ff  <= rows_ff;
      end
   end

   assign rsp_ch.valid      = rsp_valid_ff;
   assign rsp_ch.total_cost = rsp_total_ff;
   assign rsp_ch.rows_seen  = rsp_rows_ff;

endmodule
`default_nettype wire

/* sv/ssea_checker.sv */
// Checker: port-level properties of the segment SSE accumulator, and its bind.
`default_nettype none
module ssea_checker (
   input wire logic        clock,
   input wire logic        reset,
   input wire logic        req_valid,
   input wire logic        req_ready,
   input wire logic        rsp_valid,
   input wire logic        rsp_ready,
   input wire logic [61:0] rsp_total_cost
);

   // no response straight after reset
   a_rsp_idle_after_reset: assert property (@(posedge clock) reset |=> !rsp_valid)
      else $error("response valid after reset");

   // clearing pass holds off requests after reset
   a_busy_after_reset: assert property (@(posedge clock) reset |=> !req_ready)
      else $error("request taken during clearing pass");

   // one transaction at a time
   a_one_at_a_time: assert property (@(posedge clock) disable iff (reset)
      (req_valid && req_ready) |=> !req_ready)
      else $error("request taken while busy");

   // stalled response holds
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && !rsp_ready) |=> (rsp_valid && $stable(rsp_total_cost)))
      else $error("stalled response changed");

endmodule

bind segment_sse_accumulator_core ssea_checker u_ssea_checker (
   .clock          (clock),
   .reset          (reset),
   .req_valid      (req_ch.valid),
   .req_ready      (req_ch.ready),
   .rsp_valid      (rsp_ch.valid),
   .rsp_ready      (rsp_ch.ready),
   .rsp_total_cost (rsp_ch.total_cost)
);
`default_nettype wire

/* tb/segment_sse_accumulator_core_tb.sv */
// Testbench: self-checking test of the segment SSE accumulator with its own error predictor.
`timescale 1ns / 100ps
`default_nettype none
module segment_sse_accumulator_core_tb;

   localparam int LANES = 16;
   localparam logic [63:0] SUM_HI = 64'h0000_7FFF_FFFF_FFFF;
   localparam logic [63:0] SUM_LO = 64'hFFFF_8000_0000_0000;

   typedef struct packed {
      logic [1:0]  func;
      logic [3:0]  lane;
      logic [31:0] value;
      logic        is_missing;
      logic        row_end;
   } req_item_type;

   typedef struct packed {
      logic [61:0] total_cost;
      logic [15:0] rows_seen;
   } rsp_item_type;

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic csr_we = 1'b0;
   logic [61:0] csr_wdata = '0;
   int fail_count = 0;
   bit stim_done = 1'b0;

   ssea_req_if req_ch();
   ssea_rsp_if rsp_ch();

   segment_sse_accumulator_core #(.NSAMP(LANES)) i_dut (
      .clock(clock), .reset(reset), .req_ch(req_ch.sink), .rsp_ch(rsp_ch.source),
      .csr_we(csr_we), .csr_wdata(csr_wdata)
   );

   always #10 clock = ~clock;

   // predictor state
   logic [61:0] pred_loss;
   logic [15:0] pred_cnt [LANES];
   logic signed [63:0] pred_sum [LANES];
   logic [63:0] pred_sumsq [LANES];
   logic [63:0] pred_saved_err [LANES];
   logic [63:0] pred_saved_total, pred_cur_total;
   logic [15:0] pred_rows;

   req_item_type pending_reqs[$];
   rsp_item_type expected_rsps[$];

   function automatic logic [63:0] add_sat(logic [63:0] a, logic [63:0] b);
      logic [64:0] s;
      s = {1'b0, a} + {1'b0, b};
      return s[64] ? ssea_pkg::ERR_MAX : s[63:0];
   endfunction

   // sumsq - floor(sum^2/count), floored at zero
   function automatic logic [63:0] lane_open_err(int i);
      logic [127:0] mag, sq, q;
      if (pred_cnt[i] == 0) return 64'd0;
      mag = pred_sum[i] < 0 ? 128'(-pred_sum[i]) : 128'(pred_sum[i]);
      sq = mag * mag;
      q = sq / {112'd0, pred_cnt[i]};
      if (q[127:64] != 0) return 64'd0;
      return (pred_sumsq[i] > q[63:0]) ? pred_sumsq[i] - q[63:0] : 64'd0;
   endfunction

   task automatic reset_model();
      pred_loss = '0;
      for (int i = 0; i < LANES; i++) begin
         pred_cnt[i] = '0; pred_sum[i] = '0; pred_sumsq[i] = '0; pred_saved_err[i] = '0;
      end
      pred_saved_total = '0; pred_cur_total = '0; pred_rows = '0;
   endtask

   task automatic predict_error(req_item_type it);
      logic signed [63:0] v, s;
      logic [63:0] mag, st, t;
      rsp_item_type r;
      if (it.func == ssea_pkg::FUNC_ACC) begin
         if (!it.is_missing) begin
            v = 64'(signed'(it.value));
            mag = v < 0 ? -v : v;
            s = pred_sum[it.lane] + v;
            if (s > signed'(SUM_HI)) s = SUM_HI;
            if (s < signed'(SUM_LO)) s = SUM_LO;
            pred_sum[it.lane] = s;
            pred_sumsq[it.lane] = add_sat(pred_sumsq[it.lane], mag * mag);
            if (pred_cnt[it.lane] != ssea_pkg::COUNT_MAX) pred_cnt[it.lane]++;
         end
         if (it.row_end && pred_rows != ssea_pkg::COUNT_MAX) pred_rows++;
         t = '0;
         for (int i = 0; i < LANES; i++) t = add_sat(t, lane_open_err(i));
         pred_cur_total = t;
      end else if (it.func == ssea_pkg::FUNC_SAVE) begin
         st = '0;
         for (int i = 0; i < LANES; i++) begin
            pred_saved_err[i] = add_sat(pred_saved_err[i], lane_open_err(i));
            st = add_sat(st, pred_saved_err[i]);
         end
         pred_saved_total = st;
         for (int i = 0; i < LANES; i++) begin
            pred_cnt[i] = '0; pred_sum[i] = '0; pred_sumsq[i] = '0;
         end
         pred_cur_total = '0;
      end else if (it.func == ssea_pkg::FUNC_CLEAR) begin
         reset_model();
      end
      t = add_sat(add_sat({2'b0, pred_loss}, pred_saved_total), pred_cur_total);
      r.total_cost = (t > {2'b0, ssea_pkg::TOTAL_MAX}) ? ssea_pkg::TOTAL_MAX : t[61:0];
      r.rows_seen = pred_rows;
      expected_rsps.insert(expected_rsps.size(), r);
   endtask

   // driver: bursts with random gaps
   int burst_left = 0, gap_left = 0;
   always @(posedge clock) begin
      if (reset) begin
         req_ch.valid <= 1'b0;
      end else begin
         if (req_ch.valid && req_ch.ready) begin
            predict_error({req_ch.func, req_ch.lane, req_ch.value, req_ch.is_missing,
                           req_ch.row_end});
            void'(pending_reqs.pop_front());
         end
         if (!req_ch.valid || req_ch.ready) begin
            if (gap_left > 0) begin
               gap_left--;
               req_ch.valid <= 1'b0;
            end else if (pending_reqs.size() > 0) begin
               {req_ch.func, req_ch.lane, req_ch.value, req_ch.is_missing, req_ch.row_end}
                  <= pending_reqs[0];
               req_ch.valid <= 1'b1;
               if (burst_left > 0) burst_left--;
               else begin
                  burst_left = $urandom_range(0, 12);
                  gap_left = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 50);
               end
            end else begin
               req_ch.valid <= 1'b0;
            end
         end
      end
   end

   // monitor with receiver stall pattern
   int stall_phase = 0;
   always @(posedge clock) begin
      rsp_item_type exp_r;
      if (reset) begin
         rsp_ch.ready <= 1'b0;
      end else begin
         if (rsp_ch.valid && rsp_ch.ready) begin
            if (expected_rsps.size() == 0) begin
               $error("unexpected response transaction");
               fail_count++;
            end else begin
               exp_r = expected_rsps.pop_front();
               if (rsp_ch.total_cost !== exp_r.total_cost) begin
                  $error("total_cost expected %h actual %h", exp_r.total_cost,
                         rsp_ch.total_cost);
                  fail_count++;
               end
               if (rsp_ch.rows_seen !== exp_r.rows_seen) begin
                  $error("rows_seen expected %h actual %h", exp_r.rows_seen,
                         rsp_ch.rows_seen);
                  fail_count++;
               end
            end
         end
         stall_phase = (stall_phase + 1) % 256;
         // quiet stretch, then periodic stalls, then random stalls
         if (stall_phase < 80) rsp_ch.ready <= 1'b1;
         else if (stall_phase < 160) rsp_ch.ready <= (stall_phase % 7) < 4;
         else rsp_ch.ready <= ($urandom_range(0, 3) != 0);
      end
   end

   function automatic logic [31:0] pick_value();
      case ($urandom_range(0, 5))
         0: return 32'h8000_0000;
         1: return 32'h7FFF_FFFF;
         2: return $urandom_range(0, 255) << 16;
         default: return $urandom;
      endcase
   endfunction

   task automatic queue_req(logic [1:0] f, logic [3:0] l, logic [31:0] v, logic m, logic e);
      req_item_type it;
      it = '{func: f, lane: l, value: v, is_missing: m, row_end: e};
      pending_reqs.insert(pending_reqs.size(), it);
   endtask

   task automatic wait_idle();
      while (pending_reqs.size() > 0 || req_ch.valid || expected_rsps.size() > 0)
         @(posedge clock);
      repeat (60) @(posedge clock);
   endtask

   task automatic write_loss(logic [61:0] v);
      csr_we <= 1'b1;
      csr_wdata <= v;
      @(posedge clock);
      csr_we <= 1'b0;
      pred_loss = v;
      @(posedge clock);
   endtask

   initial begin
      logic [1:0] f;
      reset_model();
      req_ch.valid = 1'b0; req_ch.func = '0; req_ch.lane = '0; req_ch.value = '0;
      req_ch.is_missing = 1'b0; req_ch.row_end = 1'b0; rsp_ch.ready = 1'b0;
      repeat (6) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      write_loss(62'd0);

      // directed: extremes, every function, missing values, saturation
      queue_req(ssea_pkg::FUNC_ACC, 4'd0, 32'h8000_0000, 1'b0, 1'b1);
      queue_req(ssea_pkg::FUNC_ACC, 4'd0, 32'h7FFF_FFFF, 1'b0, 1'b0);
      queue_req(ssea_pkg::FUNC_ACC, 4'd15, 32'h7FFF_FFFF, 1'b0, 1'b1);
      queue_req(ssea_pkg::FUNC_ACC, 4'd15, 32'h7FFF_FFFF, 1'b0, 1'b0);
      queue_req(ssea_pkg::FUNC_ACC, 4'd3, 32'h0001_0000, 1'b1, 1'b1);
      queue_req(ssea_pkg::FUNC_ACC, 4'd3, 32'hFFFF_0000, 1'b0, 1'b0);
      queue_req(ssea_pkg::FUNC_SAVE, 4'd7, 32'h1234_5678, 1'b1, 1'b1);
      queue_req(ssea_pkg::FUNC_NOP, 4'd2, 32'hFFFF_FFFF, 1'b1, 1'b1);
      queue_req(ssea_pkg::FUNC_ACC, 4'd5, 32'h0000_0000, 1'b0, 1'b1);
      queue_req(ssea_pkg::FUNC_SAVE, 4'd0, 32'h0, 1'b0, 1'b0);
      for (int i = 0; i < 6; i++)
         queue_req(ssea_pkg::FUNC_ACC, 4'd9, 32'h8000_0000, 1'b0, 1'b1);
      queue_req(ssea_pkg::FUNC_CLEAR, 4'd15, 32'hFFFF_FFFF, 1'b1, 1'b1);
      wait_idle();
      write_loss(62'h3FFF_FFFF_FFFF_FFFF);
      queue_req(ssea_pkg::FUNC_ACC, 4'd1, 32'h0100_0000, 1'b0, 1'b0);
      queue_req(ssea_pkg::FUNC_ACC, 4'd1, 32'hFF00_0000, 1'b0, 1'b1);
      queue_req(ssea_pkg::FUNC_CLEAR, 4'd0, 32'h0, 1'b0, 1'b0);
      wait_idle();

      // random phases, each with its own path loss
      for (int p = 0; p < 11; p++) begin
         case (p % 3)
            0: write_loss(62'({$urandom, $urandom} & 64'h0000_00FF_FFFF_FFFF));
            1: write_loss(62'({$urandom, $urandom}));
            default: write_loss(62'd0);
         endcase
         for (int n = 0; n < 100; n++) begin
            case ($urandom_range(0, 39))
               0, 1: f = ssea_pkg::FUNC_SAVE;
               2: f = ssea_pkg::FUNC_CLEAR;
               3: f = ssea_pkg::FUNC_NOP;
               default: f = ssea_pkg::FUNC_ACC;
            endcase
            queue_req(f, 4'($urandom), pick_value(), $urandom_range(0, 7) == 0,
                      1'($urandom));
         end
         wait_idle();
      end
      stim_done = 1'b1;
   end

   // completion check
   initial begin
      wait (stim_done);
      repeat (200) @(posedge clock);
      if (fail_count == 0 && expected_rsps.size() == 0)
         $display("ALL CHECKS PASSED");
      else
         $display("CHECKS FAILED");
      $finish;
   end

   initial begin
      #20ms;
      $display("CHECKS FAILED");
      $finish;
   end
endmodule
`default_nettype wire

/* files.f */
sv/ssea_pkg.sv
sv/ssea_if.sv
sv/ssea_lane_mem.sv
sv/ssea_div.sv
sv/segment_sse_accumulator_core.sv
sv/ssea_checker.sv
tb/segment_sse_accumulator_core_tb.sv
